### rtl/core/pce_pkg.sv
// Package: constants, codes, state types and the result record of the block encoder.
package pce_pkg;

    localparam int MAX_KEY_BYTES = 32;
    localparam int MAX_RESTARTS  = 15;

    localparam int KEY_IW   = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LW   = $clog2(MAX_KEY_BYTES + 1);
    localparam int KEY_AW   = KEY_IW + 1;
    localparam int KEY_DEPTH = 2 * MAX_KEY_BYTES;
    localparam int RST_W    = $clog2(MAX_RESTARTS + 1);
    localparam int OFF_AW   = $clog2(MAX_RESTARTS);

    localparam logic [2:0] REQ_BEGIN  = 3'd0;
    localparam logic [2:0] REQ_KEY    = 3'd1;
    localparam logic [2:0] REQ_VALUE  = 3'd2;
    localparam logic [2:0] REQ_FINISH = 3'd3;
    localparam logic [2:0] REQ_RESET  = 3'd4;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_SEQ  = 2'd2;

    localparam logic [1:0] VSEL_SHARED   = 2'd0;
    localparam logic [1:0] VSEL_UNSHARED = 2'd1;
    localparam logic [1:0] VSEL_VALUE    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_KCMP,
        ST_VAR,
        ST_KEY,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_KEY,
        PH_VALUE
    } phase_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_of_run;
        logic [1:0]  status;
        logic [31:0] size_estimate;
    } result_t;

endpackage

### rtl/core/pce_out_reg.sv
// Output register stage holding one result transaction for the master side.
module pce_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pce_pkg::result_t  res,
    output logic              free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // out_byte, size_estimate
    output logic [2:0]        m_axis_tuser,   // byte_valid, status
    output logic              m_axis_tlast
);

    logic             valid_reg;
    pce_pkg::result_t data_reg;

    assign free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg.size_estimate, data_reg.out_byte};
    assign m_axis_tuser  = {data_reg.status, data_reg.byte_valid};
    assign m_axis_tlast  = data_reg.last_of_run;

endmodule

### rtl/core/prefix_compressed_block_encoder.sv
// Top level: prefix-compressed sorted-table block encoder with restart points.
// One input transaction is taken at a time. Begin, value byte, reset and out-of-sequence
// requests are handled in the decode state; a begin with an empty key then also emits the
// entry header (3 to 5 bytes). A key byte is written, then compared against the previous key
// read from the key memory; the byte that completes a key then emits the entry header
// (3 to 5 bytes) and the unshared key bytes; finish emits 4 bytes per restart
// word plus 4 for the count. Every result passes a single output register, so a stalled
// master side stalls the encoder. Keys live in a two-bank memory swapped per entry;
// restart offsets live in a 15-entry memory. No clearing pass after reset is needed.
module prefix_compressed_block_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key_length, val_len, data_byte
    input  logic [2:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_byte, size_estimate
    output logic [2:0]  m_axis_tuser,   // byte_valid, status
    output logic        m_axis_tlast
);

    localparam int KL = pce_pkg::KEY_LW;
    localparam int RW = pce_pkg::RST_W;

    pce_pkg::state_t state_reg, state_next;
    pce_pkg::phase_t phase_reg, phase_next;

    logic [2:0]  req_reg;
    logic [5:0]  klen_reg;
    logic [15:0] vlen_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  interval_reg;

    logic [KL-1:0] prev_len_reg, prev_len_next;
    logic [KL-1:0] shared_reg, shared_next;
    logic          matching_reg, matching_next;
    logic [KL-1:0] key_pos_reg, key_pos_next;
    logic [KL-1:0] pend_len_reg, pend_len_next;
    logic [15:0]   vleft_reg, vleft_next;
    logic [7:0]    entry_cnt_reg, entry_cnt_next;
    logic [31:0]   boff_reg, boff_next;
    logic [RW-1:0] rcount_reg, rcount_next;
    logic          finished_reg, finished_next;
    logic          bank_reg, bank_next;
    logic [1:0]    hdr_status_reg, hdr_status_next;
    logic [1:0]    var_sel_reg, var_sel_next;
    logic [15:0]   var_val_reg, var_val_next;
    logic [KL-1:0] key_idx_reg, key_idx_next;
    logic [RW-1:0] word_idx_reg, word_idx_next;
    logic [1:0]    byte_idx_reg, byte_idx_next;

    logic [7:0]  key_mem [0:pce_pkg::KEY_DEPTH-1];
    logic [7:0]  key_rdata_reg;
    logic        key_we;
    logic [pce_pkg::KEY_AW-1:0] key_waddr, key_raddr;

    logic [31:0] off_mem [0:pce_pkg::MAX_RESTARTS-1];
    logic [31:0] off_rdata_reg;
    logic        off_we;
    logic [pce_pkg::OFF_AW-1:0] off_waddr, off_raddr;

    logic             res_load, out_free;
    pce_pkg::result_t res;

    logic          do_close;
    logic [KL-1:0] close_len, close_sh;
    logic [1:0]    close_st;
    logic [7:0]    close_ec;

    logic          restart;
    logic [1:0]    beg_st;
    logic [7:0]    beg_ec;
    logic [KL-1:0] klen_sat;
    logic          match;
    logic [KL-1:0] shared_inc, pos_inc;
    logic [31:0]   word;

    assign s_axis_tready = (state_reg == pce_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= 8'd16;
        end
        else if (cfg_we)
        begin
            interval_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg  <= s_axis_tuser;
            klen_reg <= s_axis_tdata[5:0];
            vlen_reg <= s_axis_tdata[21:6];
            byte_reg <= s_axis_tdata[29:22];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= byte_reg;
        end
        key_rdata_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
        begin
            off_mem[off_waddr] <= boff_reg;
        end
        off_rdata_reg <= off_mem[off_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pce_pkg::ST_IDLE;
            phase_reg      <= pce_pkg::PH_IDLE;
            prev_len_reg   <= '0;
            shared_reg     <= '0;
            matching_reg   <= 1'b1;
            key_pos_reg    <= '0;
            pend_len_reg   <= '0;
            vleft_reg      <= '0;
            entry_cnt_reg  <= '0;
            boff_reg       <= '0;
            rcount_reg     <= RW'(1);
            finished_reg   <= 1'b0;
            bank_reg       <= 1'b0;
            hdr_status_reg <= pce_pkg::STATUS_OK;
            var_sel_reg    <= pce_pkg::VSEL_SHARED;
            var_val_reg    <= '0;
            key_idx_reg    <= '0;
            word_idx_reg   <= '0;
            byte_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            prev_len_reg   <= prev_len_next;
            shared_reg     <= shared_next;
            matching_reg   <= matching_next;
            key_pos_reg    <= key_pos_next;
            pend_len_reg   <= pend_len_next;
            vleft_reg      <= vleft_next;
            entry_cnt_reg  <= entry_cnt_next;
            boff_reg       <= boff_next;
            rcount_reg     <= rcount_next;
            finished_reg   <= finished_next;
            bank_reg       <= bank_next;
            hdr_status_reg <= hdr_status_next;
            var_sel_reg    <= var_sel_next;
            var_val_reg    <= var_val_next;
            key_idx_reg    <= key_idx_next;
            word_idx_reg   <= word_idx_next;
            byte_idx_reg   <= byte_idx_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        prev_len_next   = prev_len_reg;
        shared_next     = shared_reg;
        matching_next   = matching_reg;
        key_pos_next    = key_pos_reg;
        pend_len_next   = pend_len_reg;
        vleft_next      = vleft_reg;
        entry_cnt_next  = entry_cnt_reg;
        boff_next       = boff_reg;
        rcount_next     = rcount_reg;
        finished_next   = finished_reg;
        bank_next       = bank_reg;
        hdr_status_next = hdr_status_reg;
        var_sel_next    = var_sel_reg;
        var_val_next    = var_val_reg;
        key_idx_next    = key_idx_reg;
        word_idx_next   = word_idx_reg;
        byte_idx_next   = byte_idx_reg;

        key_we    = 1'b0;
        key_waddr = {~bank_reg, key_pos_reg[pce_pkg::KEY_IW-1:0]};
        off_we    = 1'b0;
        off_waddr = rcount_reg[pce_pkg::OFF_AW-1:0];

        res_load        = 1'b0;
        res.out_byte    = 8'd0;
        res.byte_valid  = 1'b0;
        res.last_of_run = 1'b0;
        res.status      = pce_pkg::STATUS_OK;

        do_close  = 1'b0;
        close_len = pend_len_reg;
        close_sh  = shared_reg;
        close_st  = pce_pkg::STATUS_OK;
        close_ec  = entry_cnt_reg;

        restart  = 1'b0;
        beg_st   = pce_pkg::STATUS_OK;
        beg_ec   = entry_cnt_reg;
        klen_sat = (klen_reg > 6'(pce_pkg::MAX_KEY_BYTES)) ? KL'(pce_pkg::MAX_KEY_BYTES)
                                                           : KL'(klen_reg);
        match    = matching_reg && (key_pos_reg < prev_len_reg) && (key_rdata_reg == byte_reg);
        shared_inc = match ? shared_reg + KL'(1) : shared_reg;
        pos_inc    = key_pos_reg + KL'(1);
        word       = 32'd0;

        case (state_reg)
            pce_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = pce_pkg::ST_DECODE;
                end
            end
            pce_pkg::ST_DECODE:
            begin
                if (req_reg == pce_pkg::REQ_KEY && phase_reg == pce_pkg::PH_KEY
                    && key_pos_reg < pend_len_reg)
                begin
                    key_we     = 1'b1;
                    state_next = pce_pkg::ST_KCMP;
                end
                else if (out_free)
                begin
                    state_next = pce_pkg::ST_IDLE;
                    if (req_reg == pce_pkg::REQ_BEGIN && phase_reg == pce_pkg::PH_IDLE
                        && !finished_reg)
                    begin
                        if (entry_cnt_reg >= interval_reg)
                        begin
                            beg_ec = 8'd0;
                            if (rcount_reg < RW'(pce_pkg::MAX_RESTARTS))
                            begin
                                off_we      = 1'b1;
                                rcount_next = rcount_reg + RW'(1);
                                restart     = 1'b1;
                            end
                            else
                            begin
                                beg_st = pce_pkg::STATUS_FULL;
                            end
                        end
                        entry_cnt_next = beg_ec;
                        pend_len_next  = klen_sat;
                        vleft_next     = vlen_reg;
                        key_pos_next   = '0;
                        shared_next    = '0;
                        matching_next  = !restart;
                        if (klen_sat == '0)
                        begin
                            do_close  = 1'b1;
                            close_len = '0;
                            close_sh  = '0;
                            close_st  = beg_st;
                            close_ec  = beg_ec;
                        end
                        else
                        begin
                            phase_next      = pce_pkg::PH_KEY;
                            res_load        = 1'b1;
                            res.status      = beg_st;
                            res.last_of_run = 1'b1;
                        end
                    end
                    else if (req_reg == pce_pkg::REQ_VALUE && phase_reg == pce_pkg::PH_VALUE)
                    begin
                        res_load        = 1'b1;
                        res.out_byte    = byte_reg;
                        res.byte_valid  = 1'b1;
                        res.last_of_run = 1'b1;
                        vleft_next      = vleft_reg - 16'd1;
                        if (vleft_reg == 16'd1)
                        begin
                            phase_next = pce_pkg::PH_IDLE;
                        end
                    end
                    else if (req_reg == pce_pkg::REQ_FINISH && phase_reg == pce_pkg::PH_IDLE
                             && !finished_reg)
                    begin
                        finished_next = 1'b1;
                        word_idx_next = '0;
                        byte_idx_next = '0;
                        state_next    = pce_pkg::ST_FIN;
                    end
                    else if (req_reg == pce_pkg::REQ_RESET)
                    begin
                        phase_next      = pce_pkg::PH_IDLE;
                        prev_len_next   = '0;
                        shared_next     = '0;
                        matching_next   = 1'b1;
                        key_pos_next    = '0;
                        pend_len_next   = '0;
                        vleft_next      = '0;
                        entry_cnt_next  = '0;
                        boff_next       = '0;
                        rcount_next     = RW'(1);
                        finished_next   = 1'b0;
                        res_load        = 1'b1;
                        res.last_of_run = 1'b1;
                    end
                    else
                    begin
                        res_load        = 1'b1;
                        res.status      = pce_pkg::STATUS_SEQ;
                        res.last_of_run = 1'b1;
                    end
                end
            end
            pce_pkg::ST_KCMP:
            begin
                shared_next   = shared_inc;
                matching_next = match;
                key_pos_next  = pos_inc;
                if (pos_inc >= pend_len_reg)
                begin
                    do_close = 1'b1;
                    close_sh = shared_inc;
                end
                else
                begin
                    state_next = pce_pkg::ST_IDLE;
                end
            end
            pce_pkg::ST_VAR:
            begin
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res.byte_valid = 1'b1;
                    res.status     = hdr_status_reg;
                    if (var_val_reg >= 16'h0080)
                    begin
                        res.out_byte = {1'b1, var_val_reg[6:0]};
                        var_val_next = var_val_reg >> 7;
                    end
                    else
                    begin
                        res.out_byte = var_val_reg[7:0];
                        case (var_sel_reg)
                            pce_pkg::VSEL_SHARED:
                            begin
                                var_sel_next = pce_pkg::VSEL_UNSHARED;
                                var_val_next = 16'(pend_len_reg - shared_reg);
                            end
                            pce_pkg::VSEL_UNSHARED:
                            begin
                                var_sel_next = pce_pkg::VSEL_VALUE;
                                var_val_next = vleft_reg;
                            end
                            default:
                            begin
                                if (key_idx_reg < pend_len_reg)
                                begin
                                    state_next = pce_pkg::ST_KEY;
                                end
                                else
                                begin
                                    res.last_of_run = 1'b1;
                                    state_next      = pce_pkg::ST_IDLE;
                                end
                            end
                        endcase
                    end
                end
            end
            pce_pkg::ST_KEY:
            begin
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = key_rdata_reg;
                    res.status     = hdr_status_reg;
                    key_idx_next   = key_idx_reg + KL'(1);
                    if (key_idx_reg + KL'(1) >= pend_len_reg)
                    begin
                        res.last_of_run = 1'b1;
                        state_next      = pce_pkg::ST_IDLE;
                    end
                end
            end
            pce_pkg::ST_FIN:
            begin
                if (word_idx_reg == rcount_reg)
                begin
                    word = 32'(rcount_reg);
                end
                else if (word_idx_reg != '0)
                begin
                    word = off_rdata_reg;
                end
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = word[8*byte_idx_reg +: 8];
                    byte_idx_next  = byte_idx_reg + 2'd1;
                    if (byte_idx_reg == 2'd3)
                    begin
                        if (word_idx_reg == rcount_reg)
                        begin
                            res.last_of_run = 1'b1;
                            state_next      = pce_pkg::ST_IDLE;
                        end
                        else
                        begin
                            word_idx_next = word_idx_reg + RW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = pce_pkg::ST_IDLE;
            end
        endcase

        if (do_close)
        begin
            prev_len_next   = close_len;
            bank_next       = ~bank_reg;
            entry_cnt_next  = (close_ec < 8'd255) ? close_ec + 8'd1 : close_ec;
            phase_next      = (vleft_next != 16'd0) ? pce_pkg::PH_VALUE : pce_pkg::PH_IDLE;
            hdr_status_next = close_st;
            var_sel_next    = pce_pkg::VSEL_SHARED;
            var_val_next    = 16'(close_sh);
            key_idx_next    = close_sh;
            state_next      = pce_pkg::ST_VAR;
        end

        if (res_load && res.byte_valid)
        begin
            boff_next = boff_reg + 32'd1;
        end
        res.size_estimate = boff_next + {{(30 - RW){1'b0}}, rcount_next, 2'b00} + 32'd4;

        key_raddr = (state_reg == pce_pkg::ST_DECODE)
                  ? {bank_reg, key_pos_reg[pce_pkg::KEY_IW-1:0]}
                  : {bank_reg, key_idx_next[pce_pkg::KEY_IW-1:0]};
        off_raddr = (word_idx_next == RW'(pce_pkg::MAX_RESTARTS))
                  ? '0 : word_idx_next[pce_pkg::OFF_AW-1:0];
    end

    pce_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_load),
        .res           (res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_load && m_axis_tvalid && !m_axis_tready))
        else $error("result loaded over a held transaction");

    a_finished_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (phase_reg == pce_pkg::PH_IDLE))
        else $error("entry in progress after finish");

    a_key_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (key_pos_reg <= pend_len_reg) && (shared_reg <= key_pos_reg))
        else $error("key position beyond key length");

    a_rcount: assert property (@(posedge clk) disable iff (!rst_n)
        (rcount_reg != '0) && (rcount_reg <= RW'(pce_pkg::MAX_RESTARTS)))
        else $error("restart count out of range");

endmodule
